### rtl/mte_pkg.sv
// Package with shared constants, register indexes and state codes of the trust evaluator.
`timescale 1ns / 1ps

package mte_pkg;

	// Default number of magnitudes kept in the window.
	localparam int WINDOW_DEPTH_DEF = 16;

	// Fixed-point constants.
	localparam logic [19:0] RATE_MAX = 20'hFFFFF;
	localparam logic [16:0] Q_ONE    = 17'd65536;
	localparam logic [16:0] Q_HALF   = 17'd32768;
	localparam int          MIN_FILL = 10;

	// Engine operand widths.
	localparam int RAD_W  = 56;
	localparam int ROOT_W = RAD_W / 2;
	localparam int NUM_W  = 48;
	localparam int DEN_W  = 32;

	// Configuration register indexes.
	localparam logic [2:0] REG_NOMINAL   = 3'd0;
	localparam logic [2:0] REG_TOLERANCE = 3'd1;
	localparam logic [2:0] REG_MAX_RATE  = 3'd2;
	localparam logic [2:0] REG_TRUST_MAX = 3'd3;
	localparam logic [2:0] REG_TRUST_MIN = 3'd4;

	// Sequencer states.
	typedef enum logic [4:0] {
		S_IDLE,
		S_SQ,
		S_MAG_GO,
		S_MAG_WAIT,
		S_WR,
		S_RMUL,
		S_RATE_GO,
		S_RATE_WAIT,
		S_RDIV_GO,
		S_RDIV_WAIT,
		S_WINIT,
		S_SUM,
		S_VAR1,
		S_VAR2,
		S_VSQ_GO,
		S_VSQ_WAIT,
		S_CDIV_GO,
		S_CDIV_WAIT,
		S_CHK,
		S_TRUST,
		S_OUT
	} state_t;

endpackage

### rtl/mte_isqrt.sv
// Iterative floor square root, two radicand bits per cycle.
`timescale 1ns / 1ps

module mte_isqrt
	import mte_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RAD_W-1:0]  radicand,
	output logic [ROOT_W-1:0] root,
	output logic              done
);

	localparam int CNT_W = $clog2(ROOT_W);

	logic [RAD_W-1:0] v_q;
	logic [RAD_W-1:0] r_q;
	logic [RAD_W-1:0] bit_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [RAD_W-1:0] trial;

	assign trial = r_q + bit_q;

	// Control: start loads, then one root bit is settled per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ROOT_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Datapath of the digit recurrence.
	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			r_q   <= '0;
			bit_q <= RAD_W'(1) << (RAD_W - 2);
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root = r_q[ROOT_W-1:0];
	assign done = done_q;

endmodule

### rtl/mte_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module mte_div
	import mte_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] numer,
	input  logic [DEN_W-1:0] denom,
	output logic [NUM_W-1:0] quot,
	output logic             done
);

	localparam int CNT_W = $clog2(NUM_W);

	logic [NUM_W-1:0] q_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;

	assign trial = {rem_q, q_q[NUM_W-1]};

	// Control counter over the numerator bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Shift the numerator out and the quotient in.
	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= numer;
			rem_q <= '0;
			den_q <= denom;
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= DEN_W'(trial - {1'b0, den_q});
				q_q   <= {q_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DEN_W-1:0];
				q_q   <= {q_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign quot = q_q;
	assign done = done_q;

endmodule

### rtl/magnetometer_trust_evaluator.sv
// Top level of the magnetometer trust evaluator: sequencer, window memory and checks.
`timescale 1ns / 1ps

// Takes one 3-axis magnetometer sample at a time and returns one result item per sample:
// the integer field magnitude, the change rate against the previous sample, a window
// consistency score and the derived reliability flag and trust weight. One item with a
// full window and a nonzero elapsed time runs three square roots and two divisions on the
// shared root and divide units, and a walk over the window memory at one entry per cycle.
// A new item is taken once the previous one has left the sequencer, even while its result
// still waits at the output register. Without a previous sample, or with no elapsed time,
// the rate path is skipped, and below ten window entries or with a zero nominal magnitude
// the window walk and its root and division are skipped too. Configuration is to be
// written only while idle; the block itself does not enforce it.

module magnetometer_trust_evaluator
	import mte_pkg::*;
#(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [19:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] field_x,
	input  logic signed [15:0] field_y,
	input  logic signed [15:0] field_z,
	input  logic [31:0]        time_ms,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        magnitude,
	output logic [19:0]        change_rate,
	output logic [16:0]        consistency,
	output logic               reliable,
	output logic [16:0]        trust
);

	localparam int FW  = $clog2(WINDOW_DEPTH + 1);
	localparam int SLW = $clog2(WINDOW_DEPTH);
	localparam int SW  = 16 + FW;
	localparam int SQW = 32 + FW;
	localparam int VW  = SQW + FW;

	// Configuration registers.
	logic [15:0] nominal_q;
	logic [6:0]  tol_q;
	logic [19:0] max_rate_q;
	logic [16:0] trust_max_q;
	logic [16:0] trust_min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nominal_q   <= 16'd500;
			tol_q       <= 7'd20;
			max_rate_q  <= 20'd1000;
			trust_max_q <= 17'd65536;
			trust_min_q <= 17'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NOMINAL:   nominal_q   <= cfg_data[15:0];
				REG_TOLERANCE: tol_q       <= cfg_data[6:0];
				REG_MAX_RATE:  max_rate_q  <= cfg_data;
				REG_TRUST_MAX: trust_max_q <= cfg_data[16:0];
				REG_TRUST_MIN: trust_min_q <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	state_t state_q, state_d;

	// Persistent state.
	logic [FW-1:0]      fill_q;
	logic [SLW-1:0]     slot_q;
	logic signed [15:0] px_q, py_q, pz_q;
	logic [31:0]        ptime_q;
	logic [19:0]        rate_q;

	// Per-item working registers.
	logic signed [15:0] x_q, y_q, z_q;
	logic [31:0]        dt_q;
	logic               have_prev_q;
	logic [2:0]         axis_q;
	logic [34:0]        acc_q;
	logic [31:0]        mag_sq_q;
	logic [33:0]        d2_q;
	logic [15:0]        mag_q;
	logic [43:0]        d2k_q;
	logic [RAD_W-1:0]   rad_q;
	logic [FW-1:0]      idx_q;
	logic               rd_v_s1;
	logic [SW-1:0]      sum_q;
	logic [SQW-1:0]     sumsq_q;
	logic [VW-1:0]      nsq_s1;
	logic [2*SW-1:0]    ss_s1;
	logic [VW-1:0]      var_q;
	logic [DEN_W-1:0]   cden_q;
	logic [16:0]        cons_q;
	logic               mag_ok_q, mag_bad_q, rate_ok_q, rate_bad_q, cons_ok_q, cons_low_q;
	logic [18:0]        prod_q;
	logic [16:0]        trust_q;

	// Output register.
	logic               out_valid_q;
	logic [15:0]        out_mag_q;
	logic [19:0]        out_rate_q;
	logic [16:0]        out_cons_q;
	logic               out_rel_q;
	logic [16:0]        out_trust_q;

	// Window memory.
	logic [16:0]        win_mem [WINDOW_DEPTH];
	logic [16:0]        rd_data_q;
	logic               mem_we;
	logic               mem_re;

	// Shared engines.
	logic               sq_start, sq_done;
	logic [RAD_W-1:0]   sq_rad;
	logic [ROOT_W-1:0]  sq_root;
	logic               dv_start, dv_done;
	logic [NUM_W-1:0]   dv_num;
	logic [DEN_W-1:0]   dv_den;
	logic [NUM_W-1:0]   dv_quot;

	mte_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sq_rad),
		.root     (sq_root),
		.done     (sq_done)
	);

	mte_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_start),
		.numer  (dv_num),
		.denom  (dv_den),
		.quot   (dv_quot),
		.done   (dv_done)
	);

	logic in_acc;
	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;

	// Square operand: an axis reading, then the difference to the previous sample.
	logic signed [16:0] opnd;
	logic signed [33:0] opnd_sq;
	logic [34:0]        acc_nx;

	always_comb begin
		case (axis_q)
			3'd0:    opnd = {x_q[15], x_q};
			3'd1:    opnd = {y_q[15], y_q};
			3'd2:    opnd = {z_q[15], z_q};
			3'd3:    opnd = {x_q[15], x_q} - {px_q[15], px_q};
			3'd4:    opnd = {y_q[15], y_q} - {py_q[15], py_q};
			default: opnd = {z_q[15], z_q} - {pz_q[15], pz_q};
		endcase
	end

	assign opnd_sq = opnd * opnd;
	assign acc_nx  = acc_q + 35'($unsigned(opnd_sq));

	// Next state and engine controls.
	always_comb begin
		state_d  = state_q;
		sq_start = 1'b0;
		sq_rad   = rad_q;
		dv_start = 1'b0;
		dv_num   = NUM_W'(sq_root);
		dv_den   = dt_q;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) state_d = S_SQ;
			end
			S_SQ: begin
				if (axis_q == 3'd5) state_d = S_MAG_GO;
			end
			S_MAG_GO: begin
				sq_start = 1'b1;
				sq_rad   = RAD_W'(mag_sq_q);
				state_d  = S_MAG_WAIT;
			end
			S_MAG_WAIT: begin
				if (sq_done) state_d = S_WR;
			end
			S_WR: begin
				mem_we  = 1'b1;
				state_d = S_RMUL;
			end
			S_RMUL: begin
				if (!have_prev_q || dt_q == '0) state_d = S_WINIT;
				else state_d = S_RATE_GO;
			end
			S_RATE_GO: begin
				sq_start = 1'b1;
				state_d  = S_RATE_WAIT;
			end
			S_RATE_WAIT: begin
				if (sq_done) state_d = S_RDIV_GO;
			end
			S_RDIV_GO: begin
				dv_start = 1'b1;
				state_d  = S_RDIV_WAIT;
			end
			S_RDIV_WAIT: begin
				if (dv_done) state_d = S_WINIT;
			end
			S_WINIT: begin
				if (fill_q < FW'(MIN_FILL) || nominal_q == '0) state_d = S_CHK;
				else state_d = S_SUM;
			end
			S_SUM: begin
				mem_re = (idx_q != fill_q);
				if (idx_q == fill_q && !rd_v_s1) state_d = S_VAR1;
			end
			S_VAR1: state_d = S_VAR2;
			S_VAR2: state_d = S_VSQ_GO;
			S_VSQ_GO: begin
				sq_start = 1'b1;
				sq_rad   = RAD_W'(var_q);
				state_d  = S_VSQ_WAIT;
			end
			S_VSQ_WAIT: begin
				if (sq_done) state_d = S_CDIV_GO;
			end
			S_CDIV_GO: begin
				dv_start = 1'b1;
				dv_num   = NUM_W'(sq_root) << 16;
				dv_den   = cden_q;
				state_d  = S_CDIV_WAIT;
			end
			S_CDIV_WAIT: begin
				if (dv_done) state_d = S_CHK;
			end
			S_CHK:   state_d = S_TRUST;
			S_TRUST: state_d = S_OUT;
			S_OUT: begin
				if (!out_valid_q || out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// Window memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) win_mem[slot_q] <= {1'b0, mag_q};
		if (mem_re) rd_data_q <= win_mem[idx_q[SLW-1:0]];
	end

	// Persistent state and control counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			slot_q  <= '0;
			px_q    <= '0;
			py_q    <= '0;
			pz_q    <= '0;
			ptime_q <= '0;
			rate_q  <= '0;
			axis_q  <= '0;
			idx_q   <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: axis_q <= '0;
				S_SQ:   axis_q <= axis_q + 1'b1;
				S_WR: begin
					if (slot_q == SLW'(WINDOW_DEPTH - 1)) slot_q <= '0;
					else slot_q <= slot_q + 1'b1;
					if (fill_q < FW'(WINDOW_DEPTH)) fill_q <= fill_q + 1'b1;
					px_q    <= x_q;
					py_q    <= y_q;
					pz_q    <= z_q;
					ptime_q <= ptime_q + dt_q;
				end
				S_RMUL: begin
					if (have_prev_q && dt_q == '0) rate_q <= '0;
				end
				S_RDIV_WAIT: begin
					if (dv_done) begin
						if (dv_quot > NUM_W'(RATE_MAX)) rate_q <= RATE_MAX;
						else rate_q <= dv_quot[19:0];
					end
				end
				S_WINIT: begin
					idx_q   <= '0;
					rd_v_s1 <= 1'b0;
				end
				S_SUM: begin
					rd_v_s1 <= mem_re;
					if (mem_re) idx_q <= idx_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Per-item datapath.
	logic [15:0] dev_abs;
	logic [22:0] dev;
	logic [22:0] lim;
	logic [20:0] cons10;
	logic [16:0] t1;
	logic [16:0] t1_hold_q;
	logic [37:0] prod10;
	logic [16:0] t2, t3;

	assign dev_abs = (mag_q > nominal_q) ? mag_q - nominal_q : nominal_q - mag_q;
	assign dev     = 23'(dev_abs) * 23'd100;
	assign lim     = 23'(nominal_q) * 23'(tol_q);
	assign cons10  = 21'(cons_q) * 21'd10;
	assign t1      = (dev > lim) ? trust_max_q >> 1 : trust_max_q;
	// Floor of the tripled value over ten by a reciprocal multiply; exact for any
	// 19-bit product.
	assign prod10  = 38'(prod_q) * 38'd419431;
	assign t2      = rate_bad_q ? {1'b0, prod10[37:22]} : t1_hold_q;
	assign t3      = cons_low_q ? t2 >> 1 : t2;

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					x_q         <= field_x;
					y_q         <= field_y;
					z_q         <= field_z;
					dt_q        <= time_ms - ptime_q;
					have_prev_q <= (fill_q != '0);
					acc_q       <= '0;
				end
			end
			S_SQ: begin
				if (axis_q == 3'd2) begin
					mag_sq_q <= acc_nx[31:0];
					acc_q    <= '0;
				end else begin
					acc_q <= acc_nx;
				end
				if (axis_q == 3'd5) d2_q <= acc_nx[33:0];
			end
			S_MAG_WAIT: begin
				if (sq_done) mag_q <= sq_root[15:0];
			end
			S_WR:   d2k_q <= 44'(d2_q) * 44'd1000;
			S_RMUL: rad_q <= RAD_W'(54'(d2k_q) * 54'd1000);
			S_WINIT: begin
				sum_q   <= '0;
				sumsq_q <= '0;
				if (fill_q < FW'(MIN_FILL)) cons_q <= Q_HALF;
				else if (nominal_q == '0) cons_q <= '0;
			end
			S_SUM: begin
				if (rd_v_s1) begin
					sum_q   <= sum_q + SW'(rd_data_q[15:0]);
					sumsq_q <= sumsq_q +
						SQW'(32'(rd_data_q[15:0]) * 32'(rd_data_q[15:0]));
				end
			end
			S_VAR1: begin
				nsq_s1 <= VW'(fill_q) * VW'(sumsq_q);
				ss_s1  <= sum_q * sum_q;
			end
			S_VAR2: begin
				var_q  <= nsq_s1 - VW'(ss_s1);
				cden_q <= DEN_W'(fill_q) * DEN_W'(nominal_q);
			end
			S_CDIV_WAIT: begin
				if (dv_done) begin
					if (dv_quot > NUM_W'(Q_ONE)) cons_q <= '0;
					else cons_q <= Q_ONE - dv_quot[16:0];
				end
			end
			S_CHK: begin
				mag_ok_q   <= dev < lim;
				mag_bad_q  <= dev > lim;
				rate_ok_q  <= rate_q < max_rate_q;
				rate_bad_q <= rate_q > max_rate_q;
				cons_ok_q  <= cons10 > 21'(6 * 65536);
				cons_low_q <= cons10 < 21'(7 * 65536);
				t1_hold_q  <= t1;
				prod_q     <= 19'(t1) * 19'd3;
			end
			S_TRUST: begin
				if (!(mag_ok_q && rate_ok_q && cons_ok_q)) trust_q <= '0;
				else if (t3 < trust_min_q) trust_q <= trust_min_q;
				else trust_q <= t3;
			end
			default: ;
		endcase
	end

	// Output register: loaded as the sequencer finishes, freed by the consumer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
			out_mag_q   <= mag_q;
			out_rate_q  <= rate_q;
			out_cons_q  <= cons_q;
			out_rel_q   <= mag_ok_q && rate_ok_q && cons_ok_q;
			out_trust_q <= trust_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign magnitude   = out_mag_q;
	assign change_rate = out_rate_q;
	assign consistency = out_cons_q;
	assign reliable    = out_rel_q;
	assign trust       = out_trust_q;

	// The sequencer takes only one item at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("new item taken while the previous one is in flight");

	// A result appears only as the sequencer finishes an item.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == S_OUT)
		else $error("result loaded outside the final state");

	// The window fill never passes the depth.
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(WINDOW_DEPTH))
		else $error("window fill exceeds depth");

	// An unreliable sample carries no trust.
	a_trust: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !reliable |-> trust == '0)
		else $error("trust given to an unreliable sample");

	// Root results arrive only while the sequencer waits for one.
	a_sq_done: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> state_q == S_MAG_WAIT || state_q == S_RATE_WAIT ||
			state_q == S_VSQ_WAIT)
		else $error("square root finished outside a wait state");

endmodule
